FILE: hw/rtl/sha1_digest_engine_assert.svh
// assertion macros shared by the sha1 digest engine modules
// depends on nothing; included by files that assert
`ifndef SHA1_DIGEST_ENGINE_ASSERT_SVH
`define SHA1_DIGEST_ENGINE_ASSERT_SVH
// implication checked every clock, off during reset
`define SHA_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

FILE: hw/rtl/sha1_pkg.sv
// shared types and constants of the sha1 digest engine
// depends on nothing
package sha1_pkg;
   localparam logic [31:0] H_INIT0 = 32'h67452301;
   localparam logic [31:0] H_INIT1 = 32'hefcdab89;
   localparam logic [31:0] H_INIT2 = 32'h98badcfe;
   localparam logic [31:0] H_INIT3 = 32'h10325476;
   localparam logic [31:0] H_INIT4 = 32'hc3d2e1f0;
   localparam logic [7:0]  PAD_MARK = 8'h80;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   // classified request passed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic wr_valid;
      logic rd_valid;
      logic rd_take;
      logic full;
   } queue_ctl_type;

   function automatic logic [31:0] round_k(input logic [6:0] t);
      logic [31:0] k;
      if (t < 7'd20) k = 32'h5a827999;
      else if (t < 7'd40) k = 32'h6ed9eba1;
      else if (t < 7'd60) k = 32'h8f1bbcdc;
      else k = 32'hca62c1d6;
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (t < 7'd20) f = (b & c) | (~b & d);
      else if (t < 7'd40) f = b ^ c ^ d;
      else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
   endfunction
endpackage

FILE: hw/rtl/sha1_front.sv
// front part: accepts requests, drops empty ones, queues commands for the back
// depends on sha1_pkg
`include "sha1_digest_engine_assert.svh"
module sha1_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_byte_valid,
   input  logic              req_end_of_message,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output sha1_pkg::cmd_type cmd
);
   sha1_pkg::cmd_type queue_ff [sha1_pkg::QUEUE_DEPTH];
   logic [sha1_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [sha1_pkg::QUEUE_AW:0] count_ff, count_in;
   sha1_pkg::queue_ctl_type ctl;

   function automatic logic [sha1_pkg::QUEUE_AW-1:0] QUEUE_INC(input logic v);
      return sha1_pkg::QUEUE_AW'(v);
   endfunction

   assign ctl.full = (count_ff == sha1_pkg::QUEUE_AW'(0) + (sha1_pkg::QUEUE_AW+1)'(sha1_pkg::QUEUE_DEPTH));
   assign req_stall = ctl.full;
   // requests with neither byte nor end change nothing
   assign ctl.wr_valid = req_valid && !ctl.full && (req_byte_valid || req_end_of_message);
   assign ctl.rd_valid = (count_ff != '0);
   assign ctl.rd_take = ctl.rd_valid && cmd_take;
   assign cmd_valid = ctl.rd_valid;
   assign cmd = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_INC(ctl.wr_valid);
      rd_ptr_in = rd_ptr_ff + QUEUE_INC(ctl.rd_take);
      count_in = count_ff + (sha1_pkg::QUEUE_AW+1)'(ctl.wr_valid)
                 - (sha1_pkg::QUEUE_AW+1)'(ctl.rd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_valid) begin
         queue_ff[wr_ptr_ff] <= '{data: req_data_byte, has_byte: req_byte_valid,
                                  finish: req_end_of_message};
      end
   end

   `SHA_ASSERT_IMP(a_no_overflow, clock, reset, ctl.full, !ctl.wr_valid, "queue overflow")
   `SHA_ASSERT_NEXT(a_count_up, clock, reset, ctl.wr_valid && !ctl.rd_take,
      count_ff == $past(count_ff) + 1'b1, "queue count lost a write")
   `SHA_ASSERT_IMP(a_empty_no_read, clock, reset, count_ff == '0, !cmd_valid,
      "read from empty queue")
endmodule

FILE: hw/rtl/sha1_back.sv
// back part: packs bytes, pads, runs 80 rounds per block, streams the digest
// depends on sha1_pkg
`include "sha1_digest_engine_assert.svh"
module sha1_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  sha1_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_digest_byte,
   output logic              rsp_digest_last
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD = 3'd3;
   localparam logic [2:0] ST_OUT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] v_ff [5];
   logic [31:0] v_in [5];
   logic [5:0] pos_ff, pos_in;
   logic [63:0] bits_ff, bits_in;
   logic [6:0] t_ff, t_in;
   logic [4:0] oidx_ff, oidx_in;
   logic finishing_ff, finishing_in;
   logic len_done_ff, len_done_in;

   logic [7:0] put_data;
   logic put_en;
   logic [31:0] sched_w, tmp;
   logic [31:0] ow;

   // schedule word: circular 16-entry buffer, rounds 16+ overwrite in place
   always_comb begin
      if (t_ff < 7'd16) sched_w = w_ff[t_ff[3:0]];
      else begin
         sched_w = w_ff[4'(t_ff[3:0] + 4'd13)] ^ w_ff[4'(t_ff[3:0] + 4'd8)]
                 ^ w_ff[4'(t_ff[3:0] + 4'd2)] ^ w_ff[t_ff[3:0]];
         sched_w = {sched_w[30:0], sched_w[31]};
      end
      tmp = {v_ff[0][26:0], v_ff[0][31:27]} + sha1_pkg::round_f(t_ff, v_ff[1], v_ff[2], v_ff[3])
            + v_ff[4] + sha1_pkg::round_k(t_ff) + sched_w;
   end

   assign ow = h_ff[oidx_ff[4:2]];
   always_comb begin
      case (oidx_ff[1:0])
         2'd0: rsp_digest_byte = ow[31:24];
         2'd1: rsp_digest_byte = ow[23:16];
         2'd2: rsp_digest_byte = ow[15:8];
         default: rsp_digest_byte = ow[7:0];
      endcase
   end
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_digest_last = (oidx_ff == 5'd19);
   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      state_in = state_ff;
      for (int i = 0; i < 5; i++) begin
         h_in[i] = h_ff[i];
         v_in[i] = v_ff[i];
      end
      for (int i = 0; i < 16; i++) w_in[i] = w_ff[i];
      pos_in = pos_ff;
      bits_in = bits_ff;
      t_in = t_ff;
      oidx_in = oidx_ff;
      finishing_in = finishing_ff;
      len_done_in = len_done_ff;
      put_en = 1'b0;
      put_data = 8'd0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               finishing_in = cmd.finish;
               len_done_in = 1'b0;
               if (cmd.has_byte) begin
                  put_en = 1'b1;
                  put_data = cmd.data;
                  bits_in = bits_ff + 64'd8;
               end else if (cmd.finish) begin
                  // no byte: start padding straight away
                  put_en = 1'b1;
                  put_data = sha1_pkg::PAD_MARK;
                  state_in = ST_PAD;
               end
               if (cmd.has_byte && cmd.finish) state_in = ST_PAD;
               // an appended byte may have just marked the pad step as pending
               if (cmd.has_byte && cmd.finish) len_done_in = 1'b1;
            end
         end
         ST_PAD: begin
            // len_done here means the pad mark still needs placing
            if (len_done_ff) begin
               put_en = 1'b1;
               put_data = sha1_pkg::PAD_MARK;
               len_done_in = 1'b0;
            end else if (pos_ff == 6'd56) begin
               w_in[14] = bits_ff[63:32];
               w_in[15] = bits_ff[31:0];
               pos_in = 6'd0;
               t_in = 7'd0;
               for (int i = 0; i < 5; i++) v_in[i] = h_ff[i];
               finishing_in = 1'b0;
               state_in = ST_ROUND;
            end else begin
               put_en = 1'b1;
               put_data = 8'd0;
            end
         end
         ST_ROUND: begin
            if (t_ff >= 7'd16) w_in[t_ff[3:0]] = sched_w;
            v_in[4] = v_ff[3];
            v_in[3] = v_ff[2];
            v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
            v_in[1] = v_ff[0];
            v_in[0] = tmp;
            t_in = t_ff + 7'd1;
            if (t_ff == 7'd79) state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int i = 0; i < 5; i++) h_in[i] = h_ff[i] + v_ff[i];
            if (finishing_ff) state_in = ST_PAD;
            else if (len_done_ff) begin
               state_in = ST_OUT;
               oidx_in = 5'd0;
            end else state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 5'd1;
               if (oidx_ff == 5'd19) begin
                  state_in = ST_IDLE;
                  h_in[0] = sha1_pkg::H_INIT0;
                  h_in[1] = sha1_pkg::H_INIT1;
                  h_in[2] = sha1_pkg::H_INIT2;
                  h_in[3] = sha1_pkg::H_INIT3;
                  h_in[4] = sha1_pkg::H_INIT4;
                  pos_in = 6'd0;
                  bits_in = 64'd0;
                  len_done_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // byte placement, with compression on a full block
      if (put_en) begin
         case (pos_ff[1:0])
            2'd0: w_in[pos_ff[5:2]] = {put_data, 24'd0};
            2'd1: w_in[pos_ff[5:2]][23:16] = put_data;
            2'd2: w_in[pos_ff[5:2]][15:8] = put_data;
            default: w_in[pos_ff[5:2]][7:0] = put_data;
         endcase
         pos_in = pos_ff + 6'd1;
         if (pos_ff == 6'd63) begin
            t_in = 7'd0;
            for (int i = 0; i < 5; i++) v_in[i] = h_ff[i];
            state_in = ST_ROUND;
            // remember to come back to padding; pending pad mark stays in len_done
            if (state_ff == ST_IDLE && !cmd.finish) begin
               finishing_in = 1'b0;
               len_done_in = 1'b0;
            end
         end
      end
      // on leaving for the final compression, mark digest pending
      if (state_ff == ST_PAD && !len_done_ff && pos_ff == 6'd56) len_done_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         bits_ff <= '0;
         h_ff[0] <= sha1_pkg::H_INIT0;
         h_ff[1] <= sha1_pkg::H_INIT1;
         h_ff[2] <= sha1_pkg::H_INIT2;
         h_ff[3] <= sha1_pkg::H_INIT3;
         h_ff[4] <= sha1_pkg::H_INIT4;
         oidx_ff <= '0;
         finishing_ff <= 1'b0;
         len_done_ff <= 1'b0;
         t_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         bits_ff <= bits_in;
         for (int i = 0; i < 5; i++) h_ff[i] <= h_in[i];
         oidx_ff <= oidx_in;
         finishing_ff <= finishing_in;
         len_done_ff <= len_done_in;
         t_ff <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) w_ff[i] <= w_in[i];
      for (int i = 0; i < 5; i++) v_ff[i] <= v_in[i];
   end

   `SHA_ASSERT_IMP(a_round_range, clock, reset, state_ff == ST_ROUND, t_ff <= 7'd79,
      "round counter out of range")
   `SHA_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(oidx_ff), "digest index moved while stalled")
   `SHA_ASSERT_IMP(a_take_idle, clock, reset, cmd_take, state_ff == ST_IDLE,
      "command taken while busy")
endmodule

FILE: hw/rtl/sha1_digest_engine.sv
// SHA-1 digest engine: takes one message byte per request and returns the 20-byte
// digest, most significant byte first, after a request with end_of_message. A queue
// of four requests sits in front of the compression core. Each byte is packed into
// the block; a byte that fills a 64-byte block starts a compression of 80 rounds at
// one per cycle and one chain add, and no new byte is taken until it is done. Finishing
// adds padding, the length words, one or two compressions and the 20 digest bytes.
// depends on sha1_pkg, sha1_front, sha1_back
module sha1_digest_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_valid,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_digest_byte,
   output logic       rsp_digest_last
);
   logic cmd_valid, cmd_take;
   sha1_pkg::cmd_type cmd;

   sha1_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte, .req_byte_valid,
      .req_end_of_message, .cmd_valid, .cmd_take, .cmd
   );

   sha1_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd, .rsp_valid, .rsp_stall,
      .rsp_digest_byte, .rsp_digest_last
   );
endmodule
